FILE: hdl/sld_pkg.sv
// Shared types, constants and helper functions of the spectral line detector.
package sld_pkg;

  localparam int BIN_BITS_DEFAULT = 16;
  localparam int REM_W = 35;

  localparam logic [7:0]  THRESHOLD_RESET = 8'd9;
  localparam logic [31:0] SPREAD_RECIP    = 32'd21474837;
  localparam logic [32:0] SPREAD_FLOOR    = 33'd12800;
  localparam logic [23:0] Q24_MAX         = 24'hFFFFFF;

  typedef struct packed {
    logic [15:0] bin_index;
    logic [31:0] power;
    logic [31:0] background;
  } bin_item_t;

  typedef struct packed {
    logic [15:0] peak_bin;
    logic [31:0] height;
    logic [23:0] quality;
    logic [23:0] cutoff_halfwidth;
    logic [23:0] window_width;
  } line_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_CLASS,
    ST_XA,
    ST_XB,
    ST_XC,
    ST_RATIO,
    ST_SQRT,
    ST_QMUL,
    ST_QWAIT,
    ST_QDIV,
    ST_DMUL,
    ST_DWAIT,
    ST_CDIV,
    ST_EMIT
  } state_t;

  typedef enum logic {
    STEP_DIV,
    STEP_SQRT
  } step_mode_t;

  typedef struct packed {
    step_mode_t       mode;
    logic [REM_W-1:0] rem;
    logic [63:0]      dvd;
    logic [63:0]      quo;
    logic [32:0]      dsr;
  } step_req_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [63:0]      dvd;
    logic [63:0]      quo;
  } step_rsp_t;

  function automatic logic [23:0] sat24(input logic [63:0] v);
    logic [23:0] r;
    r = (v > 64'(Q24_MAX)) ? Q24_MAX : v[23:0];
    return r;
  endfunction

endpackage

FILE: hdl/spectral_line_detector.sv
// Top level of the spectral line detector: sequencer, state and datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_data (sld_pkg::bin_item_t)
//   out      output     out_valid/out_ready  out_data (sld_pkg::line_item_t)
//   cfg      input      cfg_valid/cfg_ready  cfg_data (threshold ratio)
//
// A bin that neither extends a line's peak search nor closes a line ends after CLASS.
// A bin inside a line above the threshold adds the cross-product compare in XA to XC.
// A closing bin runs three 64-step divisions and one 32-step root, which share
// one step unit; the division by 100 is a reciprocal multiply.
// Reset is synchronous; cfg_ready is always high.
// A result waits in the output register; a following close stalls only if it is not taken.
module spectral_line_detector #(
  parameter int BIN_BITS = sld_pkg::BIN_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sld_pkg::bin_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sld_pkg::line_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  localparam logic [BIN_BITS:0] COUNT_MAX = '1;

  sld_pkg::state_t state, state_next;

  logic [7:0]          thr;
  logic                in_line;
  logic [BIN_BITS:0]   run_count;
  logic [31:0]         peak_power;
  logic [31:0]         peak_bg;
  logic [BIN_BITS-1:0] peak_index;

  logic [BIN_BITS-1:0] cur_bin;
  logic [31:0]         cur_p;
  logic [31:0]         cur_b;
  logic [63:0]         hold;

  logic [sld_pkg::REM_W-1:0] rem;
  logic [63:0]               dvd;
  logic [63:0]               quo;
  logic [32:0]               dsr;
  logic [5:0]                iter;
  logic [23:0]               q_reg;
  logic [23:0]               c_reg;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_q;
  logic [BIN_BITS:0] n;
  logic [39:0]       level;
  logic              p_gt, p_eq, last, out_free;

  sld_pkg::step_req_t step_req;
  sld_pkg::step_rsp_t step_rsp;

  sld_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_q)
  );

  sld_step u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  assign n        = (BIN_BITS + 1)'(peak_index) + 1'b1;
  assign level    = mul_q[39:0];
  assign p_gt     = {8'd0, cur_p} > level;
  assign p_eq     = {8'd0, cur_p} == level;
  assign last     = (iter == 6'd0);
  assign out_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      sld_pkg::ST_IDLE:  if (in_valid) state_next = sld_pkg::ST_LEVEL;
      sld_pkg::ST_LEVEL: state_next = sld_pkg::ST_CLASS;
      sld_pkg::ST_CLASS: begin
        if (in_line && p_gt) begin
          state_next = sld_pkg::ST_XA;
        end else if (in_line && !p_eq) begin
          state_next = sld_pkg::ST_RATIO;
        end else begin
          state_next = sld_pkg::ST_IDLE;
        end
      end
      sld_pkg::ST_XA:    state_next = sld_pkg::ST_XB;
      sld_pkg::ST_XB:    state_next = sld_pkg::ST_XC;
      sld_pkg::ST_XC:    state_next = sld_pkg::ST_IDLE;
      sld_pkg::ST_RATIO: if (last) state_next = sld_pkg::ST_SQRT;
      sld_pkg::ST_SQRT:  if (last) state_next = sld_pkg::ST_QMUL;
      sld_pkg::ST_QMUL:  state_next = sld_pkg::ST_QWAIT;
      sld_pkg::ST_QWAIT: state_next = sld_pkg::ST_QDIV;
      sld_pkg::ST_QDIV:  if (last) state_next = sld_pkg::ST_DMUL;
      sld_pkg::ST_DMUL:  state_next = sld_pkg::ST_DWAIT;
      sld_pkg::ST_DWAIT: state_next = sld_pkg::ST_CDIV;
      sld_pkg::ST_CDIV:  if (last) state_next = sld_pkg::ST_EMIT;
      sld_pkg::ST_EMIT:  if (out_free) state_next = sld_pkg::ST_IDLE;
      default:           state_next = sld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == sld_pkg::ST_IDLE);
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state)
      sld_pkg::ST_LEVEL: begin
        mul_a = {24'd0, thr};
        mul_b = cur_b;
      end
      sld_pkg::ST_XA: begin
        mul_a = cur_p;
        mul_b = peak_bg;
      end
      sld_pkg::ST_XB: begin
        mul_a = peak_power;
        mul_b = cur_b;
      end
      sld_pkg::ST_QMUL: begin
        mul_a = quo[31:0];
        mul_b = 32'(n);
      end
      sld_pkg::ST_DMUL: begin
        mul_a = {8'd0, q_reg};
        mul_b = sld_pkg::SPREAD_RECIP;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
    step_req.mode = (state == sld_pkg::ST_SQRT) ? sld_pkg::STEP_SQRT : sld_pkg::STEP_DIV;
    step_req.rem  = rem;
    step_req.dvd  = dvd;
    step_req.quo  = quo;
    step_req.dsr  = dsr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sld_pkg::ST_IDLE;
      thr        <= sld_pkg::THRESHOLD_RESET;
      in_line    <= 1'b0;
      run_count  <= '0;
      peak_power <= 32'd0;
      peak_bg    <= 32'd1;
      peak_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) thr <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == sld_pkg::ST_CLASS) begin
        if (!in_line && p_gt) begin
          in_line    <= 1'b1;
          run_count  <= (BIN_BITS + 1)'(2);
          peak_power <= cur_p;
          peak_bg    <= cur_b;
          peak_index <= cur_bin;
        end else if (in_line && p_gt && run_count != COUNT_MAX) begin
          run_count <= run_count + 1'b1;
        end
      end
      if (state == sld_pkg::ST_XC && hold > mul_q) begin
        peak_power <= cur_p;
        peak_bg    <= cur_b;
        peak_index <= cur_bin;
      end
      if (state == sld_pkg::ST_EMIT && out_free) begin
        out_valid <= 1'b1;
        in_line   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_bin <= BIN_BITS'(in_data.bin_index);
      cur_p   <= in_data.power;
      cur_b   <= (in_data.background == 32'd0) ? 32'd1 : in_data.background;
    end
    if (state == sld_pkg::ST_XB) hold <= mul_q;
    unique case (state)
      sld_pkg::ST_CLASS: begin
        dvd  <= {peak_power, 32'd0};
        rem  <= '0;
        quo  <= 64'd0;
        dsr  <= {1'b0, peak_bg};
        iter <= 6'd63;
      end
      sld_pkg::ST_RATIO, sld_pkg::ST_SQRT, sld_pkg::ST_QDIV, sld_pkg::ST_CDIV: begin
        rem  <= step_rsp.rem;
        dvd  <= step_rsp.dvd;
        quo  <= step_rsp.quo;
        iter <= iter - 1'b1;
        if (last) begin
          unique case (state)
            sld_pkg::ST_RATIO: begin
              dvd  <= step_rsp.quo;
              rem  <= '0;
              quo  <= 64'd0;
              iter <= 6'd31;
            end
            sld_pkg::ST_QDIV: q_reg <= sld_pkg::sat24(step_rsp.quo);
            sld_pkg::ST_CDIV: c_reg <= sld_pkg::sat24(step_rsp.quo);
            default: ;
          endcase
        end
      end
      sld_pkg::ST_QWAIT: begin
        dvd  <= mul_q;
        rem  <= '0;
        quo  <= 64'd0;
        dsr  <= 33'({run_count, 8'd0});
        iter <= 6'd63;
      end
      sld_pkg::ST_DWAIT: begin
        // The product shifted right by 31 is the quality divided by 100.
        dvd  <= 64'({n, 16'd0});
        rem  <= '0;
        quo  <= 64'd0;
        dsr  <= (mul_q[63:31] < sld_pkg::SPREAD_FLOOR) ? sld_pkg::SPREAD_FLOOR
                                                       : mul_q[63:31];
        iter <= 6'd63;
      end
      sld_pkg::ST_EMIT: begin
        if (out_free) begin
          out_data.peak_bin         <= 16'(peak_index);
          out_data.height           <= (peak_power > peak_bg) ? peak_power - peak_bg : 32'd0;
          out_data.quality          <= q_reg;
          out_data.cutoff_halfwidth <= c_reg;
          out_data.window_width     <= sld_pkg::sat24(64'({c_reg, 3'b000}));
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/sld_mul.sv
// Shared 32 by 32 bit multiplier with a registered product.
module sld_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

FILE: hdl/sld_step.sv
// Shared compare and subtract step for restoring division and square root.
module sld_step (
  input  sld_pkg::step_req_t req,
  output sld_pkg::step_rsp_t rsp
);

  logic [sld_pkg::REM_W-1:0] a;
  logic [sld_pkg::REM_W-1:0] b;
  logic [sld_pkg::REM_W-1:0] diff;
  logic                      ok;

  always_comb begin
    unique case (req.mode)
      sld_pkg::STEP_SQRT: begin
        a = {req.rem[32:0], req.dvd[63:62]};
        b = {req.quo[32:0], 2'b01};
      end
      sld_pkg::STEP_DIV: begin
        a = {req.rem[33:0], req.dvd[63]};
        b = {2'b00, req.dsr};
      end
    endcase
    diff = a - b;
    ok = (a >= b);
    rsp.rem = ok ? diff : a;
    rsp.quo = {req.quo[62:0], ok};
    rsp.dvd = (req.mode == sld_pkg::STEP_SQRT) ? {req.dvd[61:0], 2'b00}
                                               : {req.dvd[62:0], 1'b0};
  end

endmodule

FILE: hdl/sld_checker.sv
// Port-level checker for the spectral line detector and its bind statement.
module sld_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sld_pkg::line_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted again in the cycle after a transaction.");

  a_window: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.cutoff_halfwidth[23:21] != 3'd0 && out_data.window_width == 24'hFFFFFF) ||
      (out_data.cutoff_halfwidth[23:21] == 3'd0 &&
       out_data.window_width == {out_data.cutoff_halfwidth[20:0], 3'b000}))
    else $error("Window width is not eight times the cutoff half-width.");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("Result appeared without a closing computation.");

endmodule

bind spectral_line_detector sld_checker u_sld_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/spectral_line_detector_test.sv
// Self-checking testbench of the spectral line detector, with its own line-detection predictor.
module spectral_line_detector_test;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE_CYCLES = 400;
  localparam logic [63:0] P_MAX = 64'hFFFFFFFF;

  typedef enum int {
    PW_ABOVE,
    PW_TIE,
    PW_BELOW
  } power_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sld_pkg::bin_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sld_pkg::line_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  sld_pkg::line_item_t expected_lines[$];
  int errors = 0;
  int cycles = 0;
  bit idling_on = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  logic [7:0] thr_now;
  bit open_line;
  logic [16:0] run_len;
  logic [31:0] pk_pow;
  logic [31:0] pk_bg;
  logic [15:0] pk_bin;

  spectral_line_detector dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 64'd0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] clip24(input logic [63:0] v);
    return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
  endfunction

  task automatic predict_bin(input sld_pkg::bin_item_t it);
    logic [63:0] p, b, level, whole, rest, ratio, s, n, q, d, c, w;
    sld_pkg::line_item_t r;
    p = 64'(it.power);
    b = (it.background == 0) ? 64'd1 : 64'(it.background);
    level = 64'(thr_now) * b;
    if (!open_line) begin
      if (p > level) begin
        open_line = 1'b1;
        run_len = 17'd2;
        pk_pow = p[31:0];
        pk_bg = b[31:0];
        pk_bin = it.bin_index;
      end
    end else if (p > level) begin
      if (run_len != 17'h1FFFF) run_len = run_len + 17'd1;
      if (p * 64'(pk_bg) > 64'(pk_pow) * b) begin
        pk_pow = p[31:0];
        pk_bg = b[31:0];
        pk_bin = it.bin_index;
      end
    end else if (p != level) begin
      whole = 64'(pk_pow) / 64'(pk_bg);
      rest = 64'(pk_pow) % 64'(pk_bg);
      ratio = (whole << 32) | ((rest << 32) / 64'(pk_bg));
      s = root_floor(ratio);
      n = 64'(pk_bin) + 64'd1;
      q = clip24((s * n) / (64'(run_len) << 8));
      d = q / 100;
      if (d < 12800) d = 12800;
      c = clip24((n << 16) / d);
      w = clip24(c << 3);
      r.peak_bin = pk_bin;
      r.height = (pk_pow > pk_bg) ? pk_pow - pk_bg : 32'd0;
      r.quality = q[23:0];
      r.cutoff_halfwidth = c[23:0];
      r.window_width = w[23:0];
      expected_lines.push_back(r);
      open_line = 1'b0;
    end
  endtask

  // Receiver: random stall bursts, a long hold on request, and the result check.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left = stall_left - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    sld_pkg::line_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        $display("%0t: unexpected line transaction %p", $realtime, out_data);
        errors++;
      end else begin
        e = expected_lines.pop_front();
        if (out_data.peak_bin !== e.peak_bin) begin
          $display("%0t: peak_bin expected %0d actual %0d", $realtime, e.peak_bin,
                   out_data.peak_bin);
          errors++;
        end
        if (out_data.height !== e.height) begin
          $display("%0t: height expected %0d actual %0d", $realtime, e.height,
                   out_data.height);
          errors++;
        end
        if (out_data.quality !== e.quality) begin
          $display("%0t: quality expected %0d actual %0d", $realtime, e.quality,
                   out_data.quality);
          errors++;
        end
        if (out_data.cutoff_halfwidth !== e.cutoff_halfwidth) begin
          $display("%0t: cutoff_halfwidth expected %0d actual %0d", $realtime,
                   e.cutoff_halfwidth, out_data.cutoff_halfwidth);
          errors++;
        end
        if (out_data.window_width !== e.window_width) begin
          $display("%0t: window_width expected %0d actual %0d", $realtime,
                   e.window_width, out_data.window_width);
          errors++;
        end
      end
    end
  end

  // Called and returning at a falling edge; the bin is predicted at its accepting edge.
  task automatic send_bin(input logic [15:0] idx, input logic [31:0] p, input logic [31:0] b);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.bin_index = idx;
    in_data.power = p;
    in_data.background = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_bin(in_data);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_lines.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] v);
    drain();
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    thr_now = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_power(input logic [31:0] b, input power_kind_t k);
    logic [63:0] level, room;
    level = 64'(thr_now) * ((b == 0) ? 64'd1 : 64'(b));
    if (k == PW_ABOVE && level < P_MAX) begin
      room = P_MAX - level;
      return 32'(level + 1 + ({$urandom, $urandom} % room));
    end
    if (k == PW_TIE && level <= P_MAX) return level[31:0];
    if (level > P_MAX) return $urandom;
    if (level == 0) return 32'd0;
    return 32'({$urandom, $urandom} % level);
  endfunction

  function automatic logic [31:0] pick_background();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom >> $urandom_range(8, 31);
    endcase
  endfunction

  task automatic test_directed();
    send_bin(16'd0, 32'd9, 32'd1);
    send_bin(16'd1, 32'd10, 32'd1);
    send_bin(16'd2, 32'd9, 32'd1);
    send_bin(16'd3, 32'd100, 32'd1);
    send_bin(16'd4, 32'd99, 32'd1);
    send_bin(16'd5, 32'd200, 32'd2);
    send_bin(16'd6, 32'd0, 32'd1);
    send_bin(16'hFFFF, 32'hFFFFFFFF, 32'd0);
    send_bin(16'h0000, 32'hFFFFFFFF, 32'd1);
    send_bin(16'h1234, 32'd0, 32'd0);
    send_bin(16'hFFFE, 32'd10, 32'd1);
    send_bin(16'hFFFF, 32'hFFFFFFFF, 32'd2);
    send_bin(16'd7, 32'h12345678, 32'hFFFFFFFF);
    send_bin(16'd8, 32'd30, 32'd3);
    send_bin(16'd9, 32'd28, 32'd3);
    send_bin(16'd10, 32'd10, 32'd1);
    send_bin(16'd11, 32'd10, 32'd1);
    send_bin(16'd12, 32'd1, 32'd1);
    send_bin(16'd13, 32'd27, 32'd3);
  endtask

  task automatic send_random_line();
    logic [15:0] idx;
    logic [31:0] b;
    int len;
    idx = 16'($urandom);
    len = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6);
    if ($urandom_range(0, 6) == 0) begin
      b = $urandom;
      send_bin(16'($urandom), $urandom, b);
      return;
    end
    b = pick_background();
    send_bin(idx, pick_power(b, PW_ABOVE), b);
    for (int i = 0; i < len; i++) begin
      idx = idx + 16'd1;
      b = pick_background();
      send_bin(idx, pick_power(b, ($urandom_range(0, 5) == 0) ? PW_TIE : PW_ABOVE), b);
    end
    b = pick_background();
    send_bin(idx + 16'd1, pick_power(b, PW_BELOW), b);
  endtask

  task automatic test_random_lines(input int n_items);
    int start;
    start = 0;
    while (start < n_items) begin
      send_random_line();
      start = start + 9;
    end
  endtask

  task automatic test_backpressure();
    hold_left = 3000;
    for (int i = 0; i < 40; i++) begin
      send_bin(16'(i), 32'd1000, 32'd1);
      send_bin(16'(i), 32'd0, 32'd1);
    end
  endtask

  initial begin
    thr_now = sld_pkg::THRESHOLD_RESET;
    open_line = 1'b0;
    run_len = '0;
    pk_pow = '0;
    pk_bg = 32'd1;
    pk_bin = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_lines(300);
    write_threshold(8'd0);
    send_bin(16'd20, 32'd1, 32'd0);
    send_bin(16'd21, 32'd0, 32'd5);
    test_random_lines(150);
    write_threshold(8'd255);
    send_bin(16'd30, 32'd256, 32'd1);
    send_bin(16'd31, 32'd255, 32'd1);
    send_bin(16'd32, 32'd254, 32'd1);
    test_random_lines(300);
    write_threshold(8'd1);
    test_random_lines(300);
    write_threshold(8'($urandom_range(2, 254)));
    test_random_lines(300);
    write_threshold(sld_pkg::THRESHOLD_RESET);
    test_backpressure();
    drain();
    idling_on = 1'b0;
    test_random_lines(300);
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sld_pkg.sv
hdl/sld_mul.sv
hdl/sld_step.sv
hdl/spectral_line_detector.sv
hdl/sld_checker.sv
tb/spectral_line_detector_test.sv
